[rtl/core/tmbc_pkg.sv]
`default_nettype none

package tmbc_pkg;

  localparam int MAP_ROWS   = 32;
  localparam int MAP_COLS   = 256;
  localparam int ROW_W      = 5;
  localparam int COL_W      = 8;
  localparam int MAP_DEPTH  = MAP_ROWS * MAP_COLS;
  localparam int CELL_SHIFT = 10;
  localparam int POS_W      = 24;
  localparam int IDX_W      = 16;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [IDX_W-1:0] idx_t;

  localparam pos_t CELL_UNITS = pos_t'(1024);
  localparam pos_t PIXEL_UNITS = pos_t'(16);
  localparam logic [13:0] MIN_BOX_W = 14'd1920;
  localparam logic [13:0] MIN_BOX_H = 14'd2048;
  localparam pos_t WORLD_W = pos_t'(MAP_COLS) <<< CELL_SHIFT;
  localparam pos_t WORLD_H = pos_t'(MAP_ROWS) <<< CELL_SHIFT;
  localparam idx_t ROW_TOP = idx_t'(MAP_ROWS - 1);
  localparam idx_t COL_TOP = idx_t'(MAP_COLS - 1);

  localparam logic [7:0] CODE_SPACE = 8'h20;
  localparam logic [7:0] CODE_TILDE = 8'h7E;

  localparam logic FUNC_WRITE   = 1'b0;
  localparam logic FUNC_RESOLVE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_WIN,
    ST_READ,
    ST_OVERLAP,
    ST_APPLY,
    ST_DONE
  } state_e;

  // Lower window end: truncation toward zero, clamped at zero.
  function automatic idx_t win_lo(pos_t v);
    pos_t q;
    q = v >>> CELL_SHIFT;
    return (v < 0) ? '0 : idx_t'(q);
  endfunction

  // Upper window end: truncation toward zero, clamped at the map edge.
  function automatic idx_t win_hi(pos_t v, idx_t top);
    pos_t q;
    idx_t r;
    q = v >>> CELL_SHIFT;
    if (v < 0) begin
      r = (v > -CELL_UNITS) ? '0 : '1;
    end else begin
      r = (idx_t'(q) > top) ? top : idx_t'(q);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/tmbc_ram.sv]
`default_nettype none

module tmbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/core/tile_map_box_collision.sv]
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid_i/in_stall_o   | func, tile_*, pos_*, box_*, vel_*
// out     | output    | out_valid_o/out_stall_i | new_pos_*, new_vel_*, on_ground
// A write item does not stall the input and produces no result.
// A resolve item stalls the input through a vertical pass and a horizontal pass over the tiles
// in its window, and until its result is loaded; the single tile map read port sets this.
// The tile map has no reset; a tile that was never written reads back undefined.
// The block accepts a new item while a finished result waits in the output register.
`default_nettype none

module tile_map_box_collision (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        func_i,
  input  wire logic [4:0]  tile_row_i,
  input  wire logic [7:0]  tile_col_i,
  input  wire logic [7:0]  tile_code_i,
  input  wire logic signed [19:0] pos_x_i,
  input  wire logic signed [19:0] pos_y_i,
  input  wire logic [13:0] box_width_i,
  input  wire logic [13:0] box_height_i,
  input  wire logic signed [15:0] vel_x_i,
  input  wire logic signed [15:0] vel_y_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic signed [19:0] new_pos_x_o,
  output logic signed [19:0] new_pos_y_o,
  output logic signed [15:0] new_vel_x_o,
  output logic signed [15:0] new_vel_y_o,
  output logic             on_ground_o
);

  import tmbc_pkg::*;

  state_e state_q, state_d;
  pos_t px_q, py_q, bx_q, by_q;
  logic [13:0] pw_q, ph_q;
  logic signed [15:0] vx_q, vy_q;
  logic ground_q, pass_q, solid_q;
  idx_t r_q, c_q, clo_q, chi_q, rhi_q;
  pos_t ol_q, or_q, ot_q, ob_q;
  logic out_valid_q;

  logic in_acc, out_load, ram_we;
  logic [ROW_W+COL_W-1:0] waddr, raddr;
  logic [7:0] rdata;
  pos_t pw, ph, tx, ty, mx, my;
  idx_t rlo, rhi, clo, chi;
  logic win_empty, last_col, last_row, hit;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign ram_we     = in_acc && (func_i == FUNC_WRITE);
  assign waddr      = {tile_row_i, tile_col_i};
  assign raddr      = {r_q[ROW_W-1:0], c_q[COL_W-1:0]};

  tmbc_ram #(
    .WIDTH(8),
    .DEPTH(MAP_DEPTH)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(waddr),
    .wdata_i(tile_code_i),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign pw  = pos_t'(pw_q);
  assign ph  = pos_t'(ph_q);
  assign tx  = pos_t'(c_q) <<< CELL_SHIFT;
  assign ty  = pos_t'(r_q) <<< CELL_SHIFT;
  assign rlo = win_lo(py_q);
  assign clo = win_lo(px_q);
  assign rhi = win_hi(py_q + ph - PIXEL_UNITS, ROW_TOP);
  assign chi = win_hi(px_q + pw - PIXEL_UNITS, COL_TOP);
  assign win_empty = (rlo > rhi) || (clo > chi);
  assign last_col  = (c_q >= chi_q);
  assign last_row  = (r_q >= rhi_q);
  assign mx  = (ol_q < or_q) ? ol_q : or_q;
  assign my  = (ot_q < ob_q) ? ot_q : ob_q;
  assign hit = solid_q && (ol_q > 0) && (or_q > 0) && (ot_q > 0) && (ob_q > 0);
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (func_i == FUNC_RESOLVE)) begin
          state_d = ST_CLAMP;
        end
      end
      ST_CLAMP: state_d = ST_WIN;
      ST_WIN: begin
        if (!win_empty) begin
          state_d = ST_READ;
        end else if (pass_q) begin
          state_d = ST_DONE;
        end
      end
      ST_READ:    state_d = ST_OVERLAP;
      ST_OVERLAP: state_d = ST_APPLY;
      ST_APPLY: begin
        if (!last_col || !last_row) begin
          state_d = ST_READ;
        end else if (pass_q) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_WIN;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      pass_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_CLAMP) begin
        pass_q <= 1'b0;
      end else if ((state_q == ST_WIN && win_empty) ||
                   (state_q == ST_APPLY && last_col && last_row)) begin
        pass_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          px_q     <= pos_t'(pos_x_i);
          py_q     <= pos_t'(pos_y_i);
          pw_q     <= (box_width_i < MIN_BOX_W) ? MIN_BOX_W : box_width_i;
          ph_q     <= (box_height_i < MIN_BOX_H) ? MIN_BOX_H : box_height_i;
          vx_q     <= vel_x_i;
          vy_q     <= vel_y_i;
          ground_q <= 1'b0;
        end
      end
      ST_CLAMP: begin
        if (px_q < 0) begin
          px_q <= '0;
          vx_q <= '0;
        end else if (px_q + pw > WORLD_W) begin
          px_q <= WORLD_W - pw;
          vx_q <= '0;
        end
        if (py_q < 0) begin
          py_q <= '0;
          vy_q <= '0;
        end else if (py_q + ph > WORLD_H) begin
          py_q     <= WORLD_H - ph;
          vy_q     <= '0;
          ground_q <= 1'b1;
        end
      end
      ST_WIN: begin
        bx_q  <= px_q;
        by_q  <= py_q;
        r_q   <= rlo;
        c_q   <= clo;
        clo_q <= clo;
        chi_q <= chi;
        rhi_q <= rhi;
      end
      ST_READ: begin
      end
      ST_OVERLAP: begin
        solid_q <= (rdata != CODE_SPACE) && (rdata != CODE_TILDE);
        ol_q    <= bx_q + pw - tx;
        or_q    <= tx + CELL_UNITS - bx_q;
        ot_q    <= by_q + ph - ty;
        ob_q    <= ty + CELL_UNITS - by_q;
      end
      ST_APPLY: begin
        if (hit) begin
          if (!pass_q) begin
            if (my <= mx) begin
              if (ot_q < ob_q) begin
                py_q     <= ty - ph;
                ground_q <= 1'b1;
              end else begin
                py_q <= ty + CELL_UNITS;
              end
              vy_q <= '0;
            end
          end else if (mx < my) begin
            px_q <= (ol_q < or_q) ? (tx - pw) : (tx + CELL_UNITS);
          end
        end
        if (!last_col) begin
          c_q <= c_q + idx_t'(1);
        end else begin
          c_q <= clo_q;
          r_q <= r_q + idx_t'(1);
        end
      end
      ST_DONE: begin
        if (out_load) begin
          new_pos_x_o <= px_q[19:0];
          new_pos_y_o <= py_q[19:0];
          new_vel_x_o <= vx_q;
          new_vel_y_o <= vy_q;
          on_ground_o <= ground_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[rtl/core/tmbc_checker.sv]
`default_nettype none

module tmbc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        func_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [19:0] new_pos_x_o,
  input wire logic        on_ground_o
);

  import tmbc_pkg::*;

  // A resolve item keeps the input side busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && func_i == FUNC_RESOLVE) |=> in_stall_o)
    else $error("resolve item did not block input");

  // A write item leaves the block ready for the next item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && func_i == FUNC_WRITE) |=> !in_stall_o)
    else $error("write item blocked input");

  // Unless an earlier result is held by a stall, no result is shown in the cycle right after a resolve item is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && func_i == FUNC_RESOLVE && !(out_valid_o && out_stall_i))
    |=> !out_valid_o)
    else $error("result appeared too early");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
    (out_valid_o && $stable(new_pos_x_o) && $stable(on_ground_o)))
    else $error("stalled result changed");

endmodule

bind tile_map_box_collision tmbc_checker u_tmbc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .func_i      (func_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .new_pos_x_o (new_pos_x_o),
  .on_ground_o (on_ground_o)
);

`default_nettype wire

[bench/tile_map_box_collision_tb.sv]
`timescale 1ns / 1ps

module tile_map_box_collision_tb;
  import tmbc_pkg::*;

  typedef struct {
    logic                func;
    logic [4:0]          row;
    logic [7:0]          col;
    logic [7:0]          code;
    logic signed [19:0]  px;
    logic signed [19:0]  py;
    logic [13:0]         w;
    logic [13:0]         h;
    logic signed [15:0]  vx;
    logic signed [15:0]  vy;
  } cmd_t;

  typedef struct {
    logic signed [19:0] px;
    logic signed [19:0] py;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic               gnd;
  } box_state_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic func_i = FUNC_WRITE;
  logic [4:0] tile_row_i = '0;
  logic [7:0] tile_col_i = '0;
  logic [7:0] tile_code_i = '0;
  logic signed [19:0] pos_x_i = '0;
  logic signed [19:0] pos_y_i = '0;
  logic [13:0] box_width_i = '0;
  logic [13:0] box_height_i = '0;
  logic signed [15:0] vel_x_i = '0;
  logic signed [15:0] vel_y_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [19:0] new_pos_x_o;
  logic signed [19:0] new_pos_y_o;
  logic signed [15:0] new_vel_x_o;
  logic signed [15:0] new_vel_y_o;
  logic on_ground_o;

  logic [7:0] tile_shadow [MAP_DEPTH];
  box_state_t pending_boxes [$];
  bit quiet = 1'b0;
  int mismatches = 0;
  int resolves_sent = 0;
  int writes_sent = 0;
  int results_seen = 0;

  tile_map_box_collision uut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("tile_map_box_collision regression: fail");
    $finish;
  end

  function automatic box_state_t resolve_box(cmd_t c);
    box_state_t r;
    longint px, py, pw, ph, vx, vy, bx, by, c0, c1, r0, r1;
    longint tx, ty, ol, orr, ot, ob, mx, my;
    longint cell_units, ww, wh;
    logic [7:0] t;
    bit gnd;
    cell_units = 1024;
    ww = longint'(MAP_COLS) * cell_units;
    wh = longint'(MAP_ROWS) * cell_units;
    gnd = 1'b0;
    px = c.px;
    py = c.py;
    pw = c.w;
    ph = c.h;
    vx = c.vx;
    vy = c.vy;
    if (pw < 1920) pw = 1920;
    if (ph < 2048) ph = 2048;
    if (px < 0) begin
      px = 0;
      vx = 0;
    end else if (px + pw > ww) begin
      px = ww - pw;
      vx = 0;
    end
    if (py < 0) begin
      py = 0;
      vy = 0;
    end else if (py + ph > wh) begin
      py = wh - ph;
      vy = 0;
      gnd = 1'b1;
    end
    for (int pass = 0; pass < 2; pass++) begin
      bx = px;
      by = py;
      c0 = bx / cell_units;
      c1 = (bx + pw - 16) / cell_units;
      r0 = by / cell_units;
      r1 = (by + ph - 16) / cell_units;
      if (c0 < 0) c0 = 0;
      if (c1 >= MAP_COLS) c1 = MAP_COLS - 1;
      if (r0 < 0) r0 = 0;
      if (r1 >= MAP_ROWS) r1 = MAP_ROWS - 1;
      for (longint rr = r0; rr <= r1; rr++) begin
        for (longint cc = c0; cc <= c1; cc++) begin
          t = tile_shadow[rr * MAP_COLS + cc];
          if (t == CODE_SPACE || t == CODE_TILDE) continue;
          tx = cc * cell_units;
          ty = rr * cell_units;
          ol = (bx + pw) - tx;
          orr = (tx + cell_units) - bx;
          ot = (by + ph) - ty;
          ob = (ty + cell_units) - by;
          if (ol <= 0 || orr <= 0 || ot <= 0 || ob <= 0) continue;
          mx = (ol < orr) ? ol : orr;
          my = (ot < ob) ? ot : ob;
          if (pass == 0) begin
            if (my <= mx) begin
              if (ot < ob) begin
                py = ty - ph;
                gnd = 1'b1;
              end else begin
                py = ty + cell_units;
              end
              vy = 0;
            end
          end else if (mx < my) begin
            px = (ol < orr) ? (tx - pw) : (tx + cell_units);
          end
        end
      end
    end
    r.px = px[19:0];
    r.py = py[19:0];
    r.vx = vx[15:0];
    r.vy = vy[15:0];
    r.gnd = gnd;
    return r;
  endfunction

  task automatic send_item(cmd_t c);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= c.func;
    tile_row_i <= c.row;
    tile_col_i <= c.col;
    tile_code_i <= c.code;
    pos_x_i <= c.px;
    pos_y_i <= c.py;
    box_width_i <= c.w;
    box_height_i <= c.h;
    vel_x_i <= c.vx;
    vel_y_i <= c.vy;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    if (c.func == FUNC_WRITE) begin
      tile_shadow[{c.row, c.col}] = c.code;
      writes_sent++;
    end else begin
      pending_boxes.push_back(resolve_box(c));
      resolves_sent++;
    end
    @(negedge clk_i);
  endtask

  function automatic cmd_t write_cmd(int row, int col, logic [7:0] code);
    cmd_t c;
    c = '{default: '0};
    c.func = FUNC_WRITE;
    c.row = row[4:0];
    c.col = col[7:0];
    c.code = code;
    return c;
  endfunction

  function automatic cmd_t box_cmd(int px, int py, int w, int h, int vx, int vy);
    cmd_t c;
    c.func = FUNC_RESOLVE;
    c.row = 5'($urandom);
    c.col = 8'($urandom);
    c.code = 8'($urandom);
    c.px = px[19:0];
    c.py = py[19:0];
    c.w = w[13:0];
    c.h = h[13:0];
    c.vx = vx[15:0];
    c.vy = vy[15:0];
    return c;
  endfunction

  function automatic logic [7:0] random_code();
    int k;
    k = $urandom_range(0, 9);
    if (k < 4) return CODE_SPACE;
    if (k < 6) return CODE_TILDE;
    return 8'($urandom);
  endfunction

  // Boxes only ever cover the sixteen columns at either side of the map.
  function automatic int random_x(int w);
    int pw;
    int k;
    pw = (w < 1920) ? 1920 : w;
    k = $urandom_range(0, 9);
    if (k == 0) return -int'($urandom_range(1, 524288));
    if (k == 1) return $urandom_range(262145 - pw, 524287);
    if (k == 2) return $urandom_range(245760, 262144 - pw);
    return $urandom_range(0, 16384 - pw);
  endfunction

  task automatic fill_map();
    for (int r = 0; r < MAP_ROWS; r++) begin
      for (int c = 0; c < 32; c++) begin
        send_item(write_cmd(r, (c < 16) ? c : c + 224,
                            ($urandom_range(0, 5) == 0) ? 8'($urandom)
                            : (($urandom_range(0, 1) == 0) ? CODE_SPACE : CODE_TILDE)));
      end
    end
  endtask

  task automatic test_edges();
    send_item(write_cmd(10, 10, 8'h00));
    send_item(write_cmd(10, 11, 8'hFF));
    send_item(write_cmd(11, 10, CODE_SPACE));
    send_item(write_cmd(11, 11, CODE_TILDE));
    send_item(write_cmd(31, 255, 8'h23));
    send_item(box_cmd(-524288, -524288, 0, 0, -32768, -32768));
    send_item(box_cmd(524287, 524287, 16383, 16383, 32767, 32767));
    send_item(box_cmd(0, 0, 0, 0, 1, -1));
    send_item(box_cmd(262143, 32767, 0, 0, 100, 100));
    send_item(box_cmd(10 * 1024 + 100, 10 * 1024 - 2000, 0, 0, 5, 300));
    send_item(box_cmd(10 * 1024 + 100, 11 * 1024 - 300, 0, 0, 5, -300));
    send_item(box_cmd(10 * 1024 - 1900, 10 * 1024 + 500, 0, 0, 40, 0));
    send_item(box_cmd(11 * 1024 + 1000, 10 * 1024 + 500, 0, 0, -40, 0));
    send_item(box_cmd(255 * 1024, 31 * 1024, 16383, 16383, 7, 7));
    send_item(box_cmd(524287, -1, 1919, 2047, -32768, 32767));
    send_item(box_cmd(-1, 524287, 1920, 2048, 32767, -32768));
  endtask

  task automatic test_random(int count);
    int k;
    int w;
    int h;
    for (int i = 0; i < count; i++) begin
      quiet = (i > count - 200);
      k = $urandom_range(0, 9);
      if (k < 3) begin
        send_item(write_cmd($urandom_range(0, 31),
                            ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15)
                                                        : $urandom_range(240, 255),
                            random_code()));
      end else begin
        w = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 3000);
        h = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 3000);
        send_item(box_cmd(
          random_x(w),
          ($urandom_range(0, 9) == 0) ? int'($signed(20'($urandom))) : $urandom_range(0, 33000),
          w, h,
          int'($signed(16'($urandom))), int'($signed(16'($urandom)))));
      end
    end
  endtask

  initial begin
    @(negedge clk_i);
    forever begin
      if (quiet) begin
        out_stall_i <= 1'b0;
        @(negedge clk_i);
      end else begin
        out_stall_i <= $urandom_range(0, 1);
        repeat ($urandom_range(1, 11)) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    box_state_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_boxes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        e = pending_boxes.pop_front();
        if (e.px !== new_pos_x_o || e.py !== new_pos_y_o || e.vx !== new_vel_x_o ||
            e.vy !== new_vel_y_o || e.gnd !== on_ground_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp x=%0d y=%0d vx=%0d vy=%0d g=%0b",
                      " got x=%0d y=%0d vx=%0d vy=%0d g=%0b"},
                     e.px, e.py, e.vx, e.vy, e.gnd, new_pos_x_o, new_pos_y_o,
                     new_vel_x_o, new_vel_y_o, on_ground_o);
        end
      end
    end
  end

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    fill_map();
    test_edges();
    test_random(560);
    in_valid_i <= 1'b0;
    for (int i = 0; i < 200000 && pending_boxes.size() != 0; i++) @(negedge clk_i);
    repeat (2000) @(negedge clk_i);
    $display("Covered %0d tile writes and %0d box resolves; %0d results checked.",
             writes_sent, resolves_sent, results_seen);
    if (mismatches == 0 && pending_boxes.size() == 0) begin
      $display("tile_map_box_collision regression: pass");
    end else begin
      $display("%0d mismatches, %0d results missing.", mismatches, pending_boxes.size());
      $display("tile_map_box_collision regression: fail");
    end
    $finish;
  end

endmodule
